### sv/u8d_pkg.sv
// u8d_pkg: shared types and constants for the utf8 stream decoder
// used by u8d_in_stage, u8d_core and utf8_stream_decoder
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned LEFT_W    = 3;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 32;

    // substitute for a bad lead byte, ascii '?'
    localparam logic [CP_W-1:0] SUBST_CHAR = CP_W'(63);

    // lead byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [4:0] LEAD4_PFX = 5'b11110;
    localparam logic [5:0] LEAD5_PFX = 6'b111110;
    localparam logic [6:0] LEAD6_PFX = 7'b1111110;

    // continuation bytes still expected after each lead kind
    localparam logic [LEFT_W-1:0] LEFT_LEAD2 = LEFT_W'(1);
    localparam logic [LEFT_W-1:0] LEFT_LEAD3 = LEFT_W'(2);
    localparam logic [LEFT_W-1:0] LEFT_LEAD4 = LEFT_W'(3);
    localparam logic [LEFT_W-1:0] LEFT_LEAD5 = LEFT_W'(4);
    localparam logic [LEFT_W-1:0] LEFT_LEAD6 = LEFT_W'(5);

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            bad_lead;
    } t_dec_result;

endpackage : u8d_pkg

`default_nettype wire

### sv/u8d_in_stage.sv
// u8d_in_stage: input register of the decoder, one byte deep
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_in_stage
    import u8d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_ready,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              n_valid;

    // held byte leaves whenever the decode stage advances
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule : u8d_in_stage

`default_nettype wire

### sv/u8d_core.sv
// u8d_core: sequence state and per-byte decode logic
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_core
    import u8d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_dec_result            o_res
);

    logic [LEFT_W-1:0] r_bytes_left;
    logic [CP_W-1:0]   r_partial;
    logic [LEFT_W-1:0] n_bytes_left;
    logic [CP_W-1:0]   n_partial;
    logic [CP_W-1:0]   shifted;

    assign shifted = {r_partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        o_res        = '0;
        if (r_bytes_left != '0) begin
            // continuation byte, top bits not checked
            n_bytes_left = r_bytes_left - LEFT_W'(1);
            if (n_bytes_left == '0) begin
                o_res.valid      = 1'b1;
                o_res.code_point = shifted;
                n_partial        = '0;
            end else begin
                n_partial = shifted;
            end
        end else begin
            priority if (!i_byte[7]) begin
                o_res.valid      = 1'b1;
                o_res.code_point = CP_W'(i_byte);
            end else if (i_byte[7:5] == LEAD2_PFX) begin
                n_partial    = CP_W'(i_byte[4:0]);
                n_bytes_left = LEFT_LEAD2;
            end else if (i_byte[7:4] == LEAD3_PFX) begin
                n_partial    = CP_W'(i_byte[3:0]);
                n_bytes_left = LEFT_LEAD3;
            end else if (i_byte[7:3] == LEAD4_PFX) begin
                n_partial    = CP_W'(i_byte[2:0]);
                n_bytes_left = LEFT_LEAD4;
            end else if (i_byte[7:2] == LEAD5_PFX) begin
                n_partial    = CP_W'(i_byte[1:0]);
                n_bytes_left = LEFT_LEAD5;
            end else if (i_byte[7:1] == LEAD6_PFX) begin
                n_partial    = CP_W'(i_byte[0]);
                n_bytes_left = LEFT_LEAD6;
            end else begin
                // stray continuation byte (10xxxxxx), or 0xfe or 0xff
                o_res.valid      = 1'b1;
                o_res.code_point = SUBST_CHAR;
                o_res.bad_lead   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_partial    <= '0;
        end else if (i_step) begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
        end
    end

endmodule : u8d_core

`default_nettype wire

### sv/utf8_stream_decoder.sv
// utf8_stream_decoder: top level, input register, decode core, result register
// depends on u8d_pkg, u8d_in_stage and u8d_core
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_axis carries one raw byte per transfer, the stream in order
//   m_axis carries one decoded code point per transfer, bad_lead in tuser
//   single bytes and bad lead bytes give a result, a lead byte of a longer
//   sequence and its inner continuation bytes give none, the last one does
//   a bad lead byte (10xxxxxx, 0xfe, 0xff) yields '?' with tuser set
//   path: a byte transfer loads the input register, then the decode of the held
//   byte loads the result register once it is free, and that register drives
//   m_axis
//   throughput: one byte per cycle while m_axis does not stall, set by the
//   combinational decode between the input register and the result register
//   stall: when m_axis_tready is low with a result held, the input register
//   still takes one byte, then s_axis_tready drops until the result leaves
//   reset (synchronous, active low) empties both registers and drops any
//   partly received sequence
//   a sequence left unfinished stays pending until more bytes arrive

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic                       m_axis_tuser    // [0] bad_lead
);

    logic              advance;
    logic              step;
    logic              q_valid;
    logic [BYTE_W-1:0] q_byte;
    t_dec_result       dec_res;

    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_bad;
    logic              n_out_valid;

    // result register is free or drains this cycle
    assign advance = !r_out_valid || m_axis_tready;
    assign step    = q_valid && advance;

    u8d_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata[BYTE_W-1:0]),
        .o_ready   (s_axis_tready),
        .i_advance (advance),
        .o_valid   (q_valid),
        .o_byte    (q_byte)
    );

    u8d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (q_byte),
        .o_res   (dec_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = step && dec_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload loads only with a new result
    always_ff @(posedge i_clk) begin
        if (step && dec_res.valid) begin
            r_out_cp  <= dec_res.code_point;
            r_out_bad <= dec_res.bad_lead;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_cp);
    assign m_axis_tuser  = r_out_bad;

endmodule : utf8_stream_decoder

`default_nettype wire
